// File: rtl/ctmd_pkg.sv
// ----------------------------------------------------------------------------
// Command timed motor drive: shared definitions
// Field widths, register indexes, reset values and command characters.
// ----------------------------------------------------------------------------
`default_nettype none

package ctmd_pkg;

    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 15;
    localparam int unsigned STEP_W     = 14;
    localparam int unsigned BEEP_W     = 15;
    localparam int unsigned CREDIT_W   = 16;
    localparam int unsigned BYTE_W     = 8;

    typedef logic [CFG_IDX_W-1:0]  cfg_idx_t;
    typedef logic [CFG_DATA_W-1:0] cfg_data_t;
    typedef logic [BYTE_W-1:0]     byte_t;

    // Register indexes on the configuration port.
    localparam cfg_idx_t REG_STEP_AMOUNT = 2'd0;
    localparam cfg_idx_t REG_MOVE_LIMIT  = 2'd1;
    localparam cfg_idx_t REG_BEEP_AMOUNT = 2'd2;
    localparam cfg_idx_t REG_BEEP_LIMIT  = 2'd3;

    localparam logic [STEP_W-1:0] STEP_RESET = 14'd1000;
    localparam logic [BEEP_W-1:0] BEEP_RESET = 15'd1000;

    // Item kinds.
    localparam logic KIND_BYTE = 1'b0;
    localparam logic KIND_TICK = 1'b1;

    // Command characters.
    localparam byte_t CH_FORWARD    = 8'h77; // w
    localparam byte_t CH_BACK       = 8'h73; // s
    localparam byte_t CH_LEFT       = 8'h61; // a
    localparam byte_t CH_RIGHT      = 8'h64; // d
    localparam byte_t CH_SPIN_LEFT  = 8'h71; // q
    localparam byte_t CH_SPIN_RIGHT = 8'h65; // e
    localparam byte_t CH_BEEP       = 8'h20; // space

    // Pin pair of one motor after a tick.
    typedef struct packed {
        logic backward;
        logic forward;
    } motor_pins_t;

endpackage

`default_nettype wire

// File: rtl/command_timed_motor_drive_unit.sv
// A word passes through the input register, then the result register, to the output.
// Throughput: one word per cycle when out_stall is low; the input register and
// the result register form two stages, so a new word can fill an empty input
// register while a result waits to be taken. The counter update is one add and
// one compare per motor between the stages. Reset clears all counters, pins and
// stage valid flags and loads the configuration registers with 1000.
// ----------------------------------------------------------------------------
// Command timed motor drive unit
// Echoes command bytes, keeps two signed drive-time counters and a buzzer
// counter, and drives the motor and buzzer pins on every tick.
// ----------------------------------------------------------------------------
`default_nettype none

module command_timed_motor_drive_unit (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    // configuration write port
    input  wire logic                 cfg_we,
    input  wire ctmd_pkg::cfg_idx_t   cfg_index,
    input  wire ctmd_pkg::cfg_data_t  cfg_data,
    // input channel
    input  wire logic                 in_valid,
    output logic                      in_stall,
    input  wire logic                 cmd,
    input  wire ctmd_pkg::byte_t      rx_byte,
    // output channel
    output logic                      out_valid,
    input  wire logic                 out_stall,
    output logic                      tx_valid,
    output ctmd_pkg::byte_t           tx_byte,
    output logic                      left_forward,
    output logic                      left_backward,
    output logic                      right_forward,
    output logic                      right_backward,
    output logic                      buzzer_level
);
    import ctmd_pkg::*;

    localparam int unsigned EXT_W = CREDIT_W + 1;

    // Configuration registers.
    logic [STEP_W-1:0] step_amount_reg;
    logic [STEP_W-1:0] move_limit_reg;
    logic [BEEP_W-1:0] beep_amount_reg;
    logic [BEEP_W-1:0] beep_limit_reg;

    // Input stage.
    logic  in_full_reg;
    logic  kind_reg;
    byte_t byte_reg;

    // Block state.
    logic signed [CREDIT_W-1:0] left_credit_reg,  left_credit_next;
    logic signed [CREDIT_W-1:0] right_credit_reg, right_credit_next;
    logic [CREDIT_W-1:0]        beep_count_reg,   beep_count_next;
    logic                       buzzer_pin_reg,   buzzer_pin_next;
    motor_pins_t                left_pins_reg,    left_pins_next;
    motor_pins_t                right_pins_reg,   right_pins_next;

    // Result stage.
    logic  out_full_reg;
    logic  tx_valid_reg;
    byte_t tx_byte_reg;

    logic advance;

    function automatic logic signed [CREDIT_W-1:0] credit_add(
        input logic signed [CREDIT_W-1:0] c,
        input logic [STEP_W-1:0]          limit,
        input logic [STEP_W-1:0]          step
    );
        logic signed [EXT_W-1:0] c_ext;
        logic signed [EXT_W-1:0] lim_ext;
        logic signed [EXT_W-1:0] sum;
        c_ext   = EXT_W'(c);
        lim_ext = signed'({{(EXT_W-STEP_W){1'b0}}, limit});
        sum     = c_ext + signed'({{(EXT_W-STEP_W){1'b0}}, step});
        if (c_ext < lim_ext)
            return sum[CREDIT_W-1:0];
        return c;
    endfunction

    function automatic logic signed [CREDIT_W-1:0] credit_sub(
        input logic signed [CREDIT_W-1:0] c,
        input logic [STEP_W-1:0]          limit,
        input logic [STEP_W-1:0]          step
    );
        logic signed [EXT_W-1:0] c_ext;
        logic signed [EXT_W-1:0] mag;
        logic signed [EXT_W-1:0] lim_ext;
        logic signed [EXT_W-1:0] diff;
        c_ext   = EXT_W'(c);
        mag     = c_ext[EXT_W-1] ? -c_ext : c_ext;
        lim_ext = signed'({{(EXT_W-STEP_W){1'b0}}, limit});
        diff    = c_ext - signed'({{(EXT_W-STEP_W){1'b0}}, step});
        if (mag < lim_ext)
            return diff[CREDIT_W-1:0];
        return c;
    endfunction

    // The stored word moves on when the result register is empty or is
    // being emptied in this cycle.
    assign advance  = in_full_reg && (!out_full_reg || !out_stall);
    assign in_stall = in_full_reg && !advance;

    always_comb
    begin
        left_credit_next  = left_credit_reg;
        right_credit_next = right_credit_reg;
        beep_count_next   = beep_count_reg;
        buzzer_pin_next   = buzzer_pin_reg;
        left_pins_next    = left_pins_reg;
        right_pins_next   = right_pins_reg;

        if (kind_reg == KIND_BYTE)
        begin
            unique case (byte_reg)
                CH_FORWARD:
                begin
                    left_credit_next  = credit_add(left_credit_reg, move_limit_reg,
                                                   step_amount_reg);
                    right_credit_next = credit_add(right_credit_reg, move_limit_reg,
                                                   step_amount_reg);
                end
                CH_BACK:
                begin
                    left_credit_next  = credit_sub(left_credit_reg, move_limit_reg,
                                                   step_amount_reg);
                    right_credit_next = credit_sub(right_credit_reg, move_limit_reg,
                                                   step_amount_reg);
                end
                CH_LEFT:
                begin
                    right_credit_next = credit_add(right_credit_reg, move_limit_reg,
                                                   step_amount_reg);
                end
                CH_RIGHT:
                begin
                    left_credit_next  = credit_add(left_credit_reg, move_limit_reg,
                                                   step_amount_reg);
                end
                CH_SPIN_LEFT:
                begin
                    right_credit_next = credit_add(right_credit_reg, move_limit_reg,
                                                   step_amount_reg);
                    left_credit_next  = credit_sub(left_credit_reg, move_limit_reg,
                                                   step_amount_reg);
                end
                CH_SPIN_RIGHT:
                begin
                    right_credit_next = credit_sub(right_credit_reg, move_limit_reg,
                                                   step_amount_reg);
                    left_credit_next  = credit_add(left_credit_reg, move_limit_reg,
                                                   step_amount_reg);
                end
                CH_BEEP:
                begin
                    if (beep_count_reg < {1'b0, beep_limit_reg})
                        beep_count_next = beep_count_reg + {1'b0, beep_amount_reg};
                end
                default:
                begin
                end
            endcase
        end
        else
        begin
            // Each counter steps one toward zero; its sign picks the pins.
            left_pins_next = '0;
            if (left_credit_reg > 0)
            begin
                left_credit_next       = left_credit_reg - 16'sd1;
                left_pins_next.forward = 1'b1;
            end
            else if (left_credit_reg < 0)
            begin
                left_credit_next        = left_credit_reg + 16'sd1;
                left_pins_next.backward = 1'b1;
            end

            right_pins_next = '0;
            if (right_credit_reg > 0)
            begin
                right_credit_next       = right_credit_reg - 16'sd1;
                right_pins_next.forward = 1'b1;
            end
            else if (right_credit_reg < 0)
            begin
                right_credit_next        = right_credit_reg + 16'sd1;
                right_pins_next.backward = 1'b1;
            end

            if (beep_count_reg != '0)
            begin
                buzzer_pin_next = !buzzer_pin_reg;
                beep_count_next = beep_count_reg - 16'd1;
            end
            else
            begin
                buzzer_pin_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_amount_reg <= STEP_RESET;
            move_limit_reg  <= STEP_RESET;
            beep_amount_reg <= BEEP_RESET;
            beep_limit_reg  <= BEEP_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_STEP_AMOUNT: step_amount_reg <= cfg_data[STEP_W-1:0];
                REG_MOVE_LIMIT:  move_limit_reg  <= cfg_data[STEP_W-1:0];
                REG_BEEP_AMOUNT: beep_amount_reg <= cfg_data[BEEP_W-1:0];
                REG_BEEP_LIMIT:  beep_limit_reg  <= cfg_data[BEEP_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_full_reg      <= 1'b0;
            out_full_reg     <= 1'b0;
            left_credit_reg  <= '0;
            right_credit_reg <= '0;
            beep_count_reg   <= '0;
            buzzer_pin_reg   <= 1'b0;
            left_pins_reg    <= '0;
            right_pins_reg   <= '0;
        end
        else
        begin
            if (in_valid && !in_stall)
                in_full_reg <= 1'b1;
            else if (advance)
                in_full_reg <= 1'b0;

            if (advance)
                out_full_reg <= 1'b1;
            else if (!out_stall)
                out_full_reg <= 1'b0;

            if (advance)
            begin
                left_credit_reg  <= left_credit_next;
                right_credit_reg <= right_credit_next;
                beep_count_reg   <= beep_count_next;
                buzzer_pin_reg   <= buzzer_pin_next;
                left_pins_reg    <= left_pins_next;
                right_pins_reg   <= right_pins_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            kind_reg <= cmd;
            byte_reg <= rx_byte;
        end
        if (advance)
        begin
            tx_valid_reg <= (kind_reg == KIND_BYTE);
            tx_byte_reg  <= (kind_reg == KIND_BYTE) ? byte_reg : '0;
        end
    end

    // The pin state registers change only when a word moves into the
    // result register, so they read straight out as the result's pins.
    assign out_valid      = out_full_reg;
    assign tx_valid       = tx_valid_reg;
    assign tx_byte        = tx_byte_reg;
    assign left_forward   = left_pins_reg.forward;
    assign left_backward  = left_pins_reg.backward;
    assign right_forward  = right_pins_reg.forward;
    assign right_backward = right_pins_reg.backward;
    assign buzzer_level   = buzzer_pin_reg;

endmodule

`default_nettype wire

// File: rtl/ctmd_checker.sv
// ----------------------------------------------------------------------------
// Command timed motor drive checker
// Watches the ports of the unit over time and flags illegal output words.
// ----------------------------------------------------------------------------
`default_nettype none

module ctmd_checker (
    input wire logic            clk,
    input wire logic            rst_n,
    input wire logic            out_valid,
    input wire logic            out_stall,
    input wire logic            tx_valid,
    input wire ctmd_pkg::byte_t tx_byte,
    input wire logic            left_forward,
    input wire logic            left_backward,
    input wire logic            right_forward,
    input wire logic            right_backward,
    input wire logic            buzzer_level
);
    import ctmd_pkg::*;

    // A motor is never driven both ways at once.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(left_forward && left_backward) && !(right_forward && right_backward))
    else $error("motor driven forward and backward at once");

    // A tick word carries no echo byte.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !tx_valid) |-> (tx_byte == '0))
    else $error("tick word carries a byte");

    // A stalled word stays offered.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> out_valid)
    else $error("stalled word withdrawn");

    // A stalled word keeps its contents.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> ($stable(tx_valid) && $stable(tx_byte)
            && $stable(left_forward) && $stable(left_backward)
            && $stable(right_forward) && $stable(right_backward)
            && $stable(buzzer_level)))
    else $error("stalled word changed");

endmodule

bind command_timed_motor_drive_unit ctmd_checker u_ctmd_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .tx_valid       (tx_valid),
    .tx_byte        (tx_byte),
    .left_forward   (left_forward),
    .left_backward  (left_backward),
    .right_forward  (right_forward),
    .right_backward (right_backward),
    .buzzer_level   (buzzer_level)
);

`default_nettype wire
